[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TLI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table interpolator check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table interpolator check failed");

`endif

[design/tli_pkg.sv]
package tli_pkg;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int KEY_W  = 24;
    localparam int COMP_W = 4;
    localparam int CNT_W  = 5;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;

    // Default table size
    localparam int DEF_MAX_ENTRIES    = 64;
    localparam int DEF_MAX_COMPONENTS = 16;

    // Interpolation datapath widths
    localparam int DV_W      = VAL_W + 1;
    localparam int PROD_W    = KEY_W + 1 + DV_W;
    localparam int MAG_W     = KEY_W + VAL_W;
    localparam int QUO_W     = VAL_W;
    localparam int SUM_W     = VAL_W + 2;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Item functions
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OPEN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BELOW   = 3'd1;
    localparam logic [ST_W-1:0] ST_BEYOND  = 3'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd3;
    localparam logic [ST_W-1:0] ST_REJECT  = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic            accept;
        logic            advance;
        logic            setup;
        logic            mul;
        logic            absval;
        logic            div_step;
        logic            finish;
        logic            fail;
        logic [ST_W-1:0] fail_st;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic below;
        logic missing;
        logic bracket;
        logic last;
    } stat_t;

endpackage

[design/tli_ctrl.sv]
module tli_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tli_pkg::FUNC_W-1:0] func,
    input  tli_pkg::stat_t            stat,
    output logic                      busy,
    output tli_pkg::cmd_t             cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ABS  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [tli_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [tli_pkg::DIV_CNT_W-1:0]   div_cnt_next;

    // Sequence the walk, the multiply and the divide
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (func == tli_pkg::FUNC_QUERY && !stat.empty)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.below)
                begin
                    cmd.fail    = 1'b1;
                    cmd.fail_st = tli_pkg::ST_BELOW;
                    state_next  = S_IDLE;
                end
                else if (stat.missing)
                begin
                    cmd.fail    = 1'b1;
                    cmd.fail_st = tli_pkg::ST_MISSING;
                    state_next  = S_IDLE;
                end
                else if (stat.bracket)
                begin
                    cmd.setup  = 1'b1;
                    state_next = S_MUL;
                end
                else if (stat.last)
                begin
                    cmd.fail    = 1'b1;
                    cmd.fail_st = tli_pkg::ST_BEYOND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.absval   = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == tli_pkg::DIV_CNT_W'(tli_pkg::QUO_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

[design/tli_dpath.sv]
module tli_dpath
#(
    parameter int MAX_ENTRIES    = tli_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_COMPONENTS = tli_pkg::DEF_MAX_COMPONENTS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tli_pkg::FUNC_W-1:0]        func,
    input  logic [tli_pkg::KEY_W-1:0]         key,
    input  logic [tli_pkg::COMP_W-1:0]        component,
    input  logic [tli_pkg::CNT_W-1:0]         comp_count,
    input  logic signed [tli_pkg::VAL_W-1:0]  value,
    input  tli_pkg::cmd_t                     cmd,
    output tli_pkg::stat_t                    stat,
    output logic                              done,
    output logic signed [tli_pkg::VAL_W-1:0]  result,
    output logic [tli_pkg::ST_W-1:0]          status
);

    localparam int EW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int DEPTH = MAX_ENTRIES * MAX_COMPONENTS;
    localparam int AW    = $clog2(DEPTH);

    // Table storage
    logic [tli_pkg::KEY_W-1:0]        key_mem [MAX_ENTRIES];
    logic [tli_pkg::CNT_W-1:0]        cnt_mem [MAX_ENTRIES];
    logic signed [tli_pkg::VAL_W-1:0] val_mem [DEPTH];

    logic [tli_pkg::KEY_W-1:0]        key_rd_reg;
    logic [tli_pkg::CNT_W-1:0]        cnt_rd_reg;
    logic signed [tli_pkg::VAL_W-1:0] val_rd_reg;

    // Table bookkeeping
    logic [CW-1:0]                    entry_total_reg;
    logic [CW-1:0]                    entry_total_next;
    logic [tli_pkg::KEY_W-1:0]        last_key_reg;
    logic [tli_pkg::CNT_W-1:0]        last_count_reg;

    // Query state
    logic [tli_pkg::KEY_W-1:0]        q_key_reg;
    logic [tli_pkg::COMP_W-1:0]       q_comp_reg;
    logic [EW-1:0]                    idx_reg;
    logic [EW-1:0]                    idx_next;
    logic [tli_pkg::KEY_W-1:0]        k0_reg;
    logic signed [tli_pkg::VAL_W-1:0] v0_reg;

    // Interpolation arithmetic
    logic [tli_pkg::KEY_W-1:0]         dk_reg;
    logic [tli_pkg::KEY_W-1:0]         den_reg;
    logic signed [tli_pkg::DV_W-1:0]   dv_reg;
    logic signed [tli_pkg::PROD_W-1:0] prod_reg;
    logic                              neg_reg;
    logic [tli_pkg::KEY_W-1:0]         rem_reg;
    logic [tli_pkg::QUO_W-1:0]         quo_reg;

    // Result
    logic                              done_reg;
    logic                              done_next;
    logic signed [tli_pkg::VAL_W-1:0]  result_reg;
    logic [tli_pkg::ST_W-1:0]          status_reg;

    logic                              open_ok;
    logic                              write_ok;
    logic                              key_we;
    logic                              val_we;
    logic [EW-1:0]                     new_idx;
    logic [AW-1:0]                     val_waddr;
    logic [AW-1:0]                     val_raddr;
    logic [tli_pkg::PROD_W-1:0]        mag_full;
    logic [tli_pkg::KEY_W:0]           trial;
    logic                              qbit;
    logic signed [tli_pkg::SUM_W-1:0]  sum;
    logic signed [tli_pkg::VAL_W-1:0]  sat;

    // Decode load items against the newest entry
    always_comb
    begin
        open_ok = (entry_total_reg < CW'(MAX_ENTRIES))
               && (32'(comp_count) <= 32'(MAX_COMPONENTS))
               && ((entry_total_reg == '0) || (key > last_key_reg));
        write_ok = (entry_total_reg != '0)
                && (tli_pkg::CNT_W'(component) < last_count_reg)
                && (32'(component) < 32'(MAX_COMPONENTS));
        key_we  = cmd.accept && (func == tli_pkg::FUNC_OPEN) && open_ok;
        val_we  = cmd.accept && (func == tli_pkg::FUNC_WRITE) && write_ok;
        new_idx = entry_total_reg[EW-1:0];
        val_waddr = AW'(32'(entry_total_reg - 1'b1) * MAX_COMPONENTS + 32'(component));
        val_raddr = AW'(32'(idx_reg) * MAX_COMPONENTS + 32'(q_comp_reg));
    end

    // Write and read the key and count stores
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[new_idx] <= key;
            cnt_mem[new_idx] <= comp_count;
        end
        key_rd_reg <= key_mem[idx_reg];
        cnt_rd_reg <= cnt_mem[idx_reg];
    end

    // Write and read the value store
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= value;
        end
        val_rd_reg <= val_mem[val_raddr];
    end

    // Report the walk position to the controller
    always_comb
    begin
        stat.empty   = (entry_total_reg == '0);
        stat.bracket = (q_key_reg < key_rd_reg);
        stat.below   = (idx_reg == '0) && (q_key_reg < key_rd_reg);
        stat.missing = (cnt_rd_reg <= tli_pkg::CNT_W'(q_comp_reg))
                    || (32'(q_comp_reg) >= 32'(MAX_COMPONENTS));
        stat.last    = (CW'(idx_reg) == (entry_total_reg - 1'b1));
    end

    // Next values of the control registers
    always_comb
    begin
        entry_total_next = entry_total_reg;
        idx_next         = idx_reg;
        done_next        = cmd.finish || cmd.fail;
        if (cmd.accept)
        begin
            if (func == tli_pkg::FUNC_CLEAR)
            begin
                entry_total_next = '0;
            end
            else if (key_we)
            begin
                entry_total_next = entry_total_reg + 1'b1;
            end
            if (func == tli_pkg::FUNC_QUERY)
            begin
                idx_next  = '0;
                done_next = (entry_total_reg == '0);
            end
            else
            begin
                done_next = 1'b1;
            end
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Restoring divide step and final sum with saturation
    always_comb
    begin
        mag_full = prod_reg[tli_pkg::PROD_W-1] ? (~prod_reg + 1'b1) : prod_reg;
        trial    = {rem_reg, quo_reg[tli_pkg::QUO_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        sum      = neg_reg ? (tli_pkg::SUM_W'(v0_reg) - tli_pkg::SUM_W'(quo_reg))
                           : (tli_pkg::SUM_W'(v0_reg) + tli_pkg::SUM_W'(quo_reg));
        if (sum[tli_pkg::SUM_W-1:tli_pkg::VAL_W-1] == '0
            || sum[tli_pkg::SUM_W-1:tli_pkg::VAL_W-1] == '1)
        begin
            sat = sum[tli_pkg::VAL_W-1:0];
        end
        else if (sum[tli_pkg::SUM_W-1])
        begin
            sat = {1'b1, {(tli_pkg::VAL_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(tli_pkg::VAL_W-1){1'b1}}};
        end
    end

    // Hold the table size, walk index and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total_reg <= '0;
            idx_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            entry_total_reg <= entry_total_next;
            idx_reg         <= idx_next;
            done_reg        <= done_next;
        end
    end

    // Advance the payload registers on each command
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            last_key_reg   <= key;
            last_count_reg <= comp_count;
        end
        if (cmd.accept)
        begin
            q_key_reg  <= key;
            q_comp_reg <= component;
            result_reg <= '0;
            if (func == tli_pkg::FUNC_OPEN)
            begin
                status_reg <= open_ok ? tli_pkg::ST_OK : tli_pkg::ST_REJECT;
            end
            else if (func == tli_pkg::FUNC_WRITE)
            begin
                status_reg <= write_ok ? tli_pkg::ST_OK : tli_pkg::ST_REJECT;
            end
            else if (func == tli_pkg::FUNC_QUERY)
            begin
                status_reg <= tli_pkg::ST_BEYOND;
            end
            else
            begin
                status_reg <= tli_pkg::ST_OK;
            end
        end
        if (cmd.advance)
        begin
            k0_reg <= key_rd_reg;
            v0_reg <= val_rd_reg;
        end
        if (cmd.setup)
        begin
            dk_reg  <= q_key_reg - k0_reg;
            den_reg <= key_rd_reg - k0_reg;
            dv_reg  <= {val_rd_reg[tli_pkg::VAL_W-1], val_rd_reg}
                     - {v0_reg[tli_pkg::VAL_W-1], v0_reg};
        end
        if (cmd.mul)
        begin
            prod_reg <= $signed({1'b0, dk_reg}) * dv_reg;
        end
        if (cmd.absval)
        begin
            neg_reg <= prod_reg[tli_pkg::PROD_W-1];
            rem_reg <= mag_full[tli_pkg::MAG_W-1:tli_pkg::QUO_W];
            quo_reg <= mag_full[tli_pkg::QUO_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? (trial[tli_pkg::KEY_W-1:0] - den_reg) : trial[tli_pkg::KEY_W-1:0];
            quo_reg <= {quo_reg[tli_pkg::QUO_W-2:0], qbit};
        end
        if (cmd.finish)
        begin
            result_reg <= sat;
            status_reg <= tli_pkg::ST_OK;
        end
        if (cmd.fail)
        begin
            result_reg <= '0;
            status_reg <= cmd.fail_st;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign status = status_reg;

endmodule

[design/table_linear_interpolator.sv]
// Piecewise linear lookup table with up to MAX_ENTRIES breakpoints of
// up to MAX_COMPONENTS signed Q8.24 values, keyed by unsigned Q16.8.
// Command channel: func/key/component/comp_count/value are taken at a rising
// edge where start is high and busy is low. Clear, open and write items
// finish at that edge, and busy stays low, so they may be issued every cycle.
// A query raises busy while the controller walks the table, each entry taking
// a read state (key, count and value memories) and then a compare state; it
// then multiplies once and runs a radix-2 restoring divider for a 32-bit quotient.
// Result channel: done is high for exactly one cycle with result and status;
// every item gives one transfer, and the receiver cannot hold it off.
// The result is registered at the accepting edge for loads and for a query of
// an empty table, at the compare that flags a query, and in the finish state
// after the multiply, magnitude and divide states for one that interpolates.
// Busy is low in the cycle that carries done, so the next item can be taken
// at that same edge. Reset empties the table and returns the controller to
// idle; table memories are not cleared. Entries are only read once opened,
// but a component value is read whether or not it was written.
module table_linear_interpolator
#(
    parameter int MAX_ENTRIES    = tli_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_COMPONENTS = tli_pkg::DEF_MAX_COMPONENTS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tli_pkg::FUNC_W-1:0]        func,
    input  logic [tli_pkg::KEY_W-1:0]         key,
    input  logic [tli_pkg::COMP_W-1:0]        component,
    input  logic [tli_pkg::CNT_W-1:0]         comp_count,
    input  logic signed [tli_pkg::VAL_W-1:0]  value,
    output logic                              done,
    output logic signed [tli_pkg::VAL_W-1:0]  result,
    output logic [tli_pkg::ST_W-1:0]          status
);

    tli_pkg::cmd_t  cmd;
    tli_pkg::stat_t stat;

    // Sequence each item
    tli_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Hold the table and compute results
    tli_dpath
    #(
        .MAX_ENTRIES    (MAX_ENTRIES),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (func),
        .key        (key),
        .component  (component),
        .comp_count (comp_count),
        .value      (value),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .result     (result),
        .status     (status)
    );

endmodule

[design/tli_checker.sv]
`include "assert_macros.svh"

module tli_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [tli_pkg::FUNC_W-1:0]       func,
    input logic                             done,
    input logic signed [tli_pkg::VAL_W-1:0] result,
    input logic [tli_pkg::ST_W-1:0]         status
);

    // A result transfer always leaves the block ready for the next item
    `TLI_ASSERT_IMPL(a_done_not_busy, done, !busy)

    // A load item is done in the cycle after it is taken, without raising busy
    `TLI_ASSERT_NEXT(a_load_one_cycle, start && !busy && func != tli_pkg::FUNC_QUERY, done && !busy)

    // A query either starts the walk or reports an empty table at once
    `TLI_ASSERT_NEXT(a_query_start, start && !busy && func == tli_pkg::FUNC_QUERY, busy || (done && status == tli_pkg::ST_BEYOND))

    // Results with a status other than OK (flags, rejected loads) carry a zero value
    `TLI_ASSERT_IMPL(a_flag_zero, done && status != tli_pkg::ST_OK, result == 0)

endmodule

bind table_linear_interpolator tli_checker u_tli_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .func   (func),
    .done   (done),
    .result (result),
    .status (status)
);

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int FUNC_W = tli_pkg::FUNC_W;
    localparam int KEY_W  = tli_pkg::KEY_W;
    localparam int COMP_W = tli_pkg::COMP_W;
    localparam int CNT_W  = tli_pkg::CNT_W;
    localparam int VAL_W  = tli_pkg::VAL_W;
    localparam int ST_W   = tli_pkg::ST_W;

    localparam int ENTRIES      = tli_pkg::DEF_MAX_ENTRIES;
    localparam int COMPS        = tli_pkg::DEF_MAX_COMPONENTS;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 170;
    localparam int MAX_GAP      = 30;
    localparam int ITEMS_PER_PHASE = 200;
    localparam longint VAL_MAX  = 64'sd2147483647;
    localparam longint VAL_MIN  = -VAL_MAX - 1;
    localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};
    localparam logic signed [VAL_W-1:0] VAL_MOST  = 32'sh7FFFFFFF;
    localparam logic signed [VAL_W-1:0] VAL_LEAST = 32'sh80000000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [FUNC_W-1:0]        func;
    logic [KEY_W-1:0]         key;
    logic [COMP_W-1:0]        component;
    logic [CNT_W-1:0]         comp_count;
    logic signed [VAL_W-1:0]  value;
    logic                     done;
    logic signed [VAL_W-1:0]  result;
    logic [ST_W-1:0]          status;

    // Table mirror: predicts one outcome per transfer and checks results in order
    class lookup_scoreboard;
        typedef struct packed {
            logic signed [VAL_W-1:0] res;
            logic [ST_W-1:0]         st;
        } outcome_t;

        logic [KEY_W-1:0]        keys [ENTRIES];
        logic [CNT_W-1:0]        counts [ENTRIES];
        logic signed [VAL_W-1:0] vals [ENTRIES][COMPS];
        bit [COMPS-1:0]          written [ENTRIES];
        int                      entries;
        int                      errors;
        outcome_t                pending_outcomes[$];

        function new();
            entries = 0;
            errors  = 0;
        endfunction

        // Walk the breakpoints and interpolate between the bracketing pair
        function outcome_t interpolate(logic [KEY_W-1:0] k, logic [COMP_W-1:0] c);
            outcome_t o;
            longint   k0, v0, v, num, q, r;
            o.res = '0;
            o.st  = tli_pkg::ST_BEYOND;
            k0 = 0;
            v0 = 0;
            if (entries == 0)
                return o;
            if (k < keys[0])
            begin
                o.st = tli_pkg::ST_BELOW;
                return o;
            end
            for (int i = 0; i < entries; i++)
            begin
                if (counts[i] <= c)
                begin
                    o.st = tli_pkg::ST_MISSING;
                    return o;
                end
                v = vals[i][c];
                if (k >= keys[i])
                begin
                    k0 = keys[i];
                    v0 = v;
                end
                else
                begin
                    num = (longint'(k) - k0) * (v - v0);
                    q   = num / (longint'(keys[i]) - k0);
                    r   = v0 + q;
                    if (r > VAL_MAX)
                        r = VAL_MAX;
                    if (r < VAL_MIN)
                        r = VAL_MIN;
                    o.res = r[VAL_W-1:0];
                    o.st  = tli_pkg::ST_OK;
                    return o;
                end
            end
            return o;
        endfunction

        // True when a query would touch a component that was never loaded
        function bit reads_unwritten(logic [KEY_W-1:0] k, logic [COMP_W-1:0] c);
            if (entries == 0 || k < keys[0])
                return 1'b0;
            for (int i = 0; i < entries; i++)
            begin
                if (counts[i] <= c)
                    return 1'b0;
                if (!written[i][c])
                    return 1'b1;
                if (k < keys[i])
                    return 1'b0;
            end
            return 1'b0;
        endfunction

        // Update the mirror for an accepted transfer and queue its outcome
        function void note_item(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                logic [COMP_W-1:0] c, logic [CNT_W-1:0] n,
                                logic signed [VAL_W-1:0] v);
            outcome_t o;
            o.res = '0;
            o.st  = tli_pkg::ST_OK;
            case (f)
                tli_pkg::FUNC_CLEAR:
                    entries = 0;
                tli_pkg::FUNC_OPEN:
                    if (entries >= ENTRIES || n > COMPS ||
                        (entries > 0 && k <= keys[entries-1]))
                        o.st = tli_pkg::ST_REJECT;
                    else
                    begin
                        keys[entries]    = k;
                        counts[entries]  = n;
                        written[entries] = '0;
                        for (int j = 0; j < COMPS; j++)
                            vals[entries][j] = '0;
                        entries++;
                    end
                tli_pkg::FUNC_WRITE:
                    if (entries == 0 || c >= counts[entries-1])
                        o.st = tli_pkg::ST_REJECT;
                    else
                    begin
                        vals[entries-1][c]    = v;
                        written[entries-1][c] = 1'b1;
                    end
                default:
                    o = interpolate(k, c);
            endcase
            pending_outcomes = {pending_outcomes, o};
        endfunction

        // Compare one result with the oldest outcome still owed
        function void check_result(logic signed [VAL_W-1:0] res, logic [ST_W-1:0] st);
            outcome_t o;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %0d status %0d", res, st);
                return;
            end
            o = pending_outcomes.pop_front();
            if (res !== o.res || st !== o.st)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: result exp %0d got %0d, status exp %0d got %0d",
                             o.res, res, o.st, st);
            end
        endfunction
    endclass

    lookup_scoreboard sb;
    int idle_pct;
    int sent;
    int quiet_cycles;

    table_linear_interpolator u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .key        (key),
        .component  (component),
        .comp_count (comp_count),
        .value      (value),
        .done       (done),
        .result     (result),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Check every result strobe
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(result, status);
    end

    // End the run when neither side moves a transfer for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Drive one command, hold it until the block takes it
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                         input logic [COMP_W-1:0] c, input logic [CNT_W-1:0] n,
                         input logic signed [VAL_W-1:0] v);
        int gap;
        gap = 0;
        while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            gap++;
        end
        @(negedge clk);
        start      <= 1'b1;
        func       <= f;
        key        <= k;
        component  <= c;
        comp_count <= n;
        value      <= v;
        // busy only moves at the rising edge, so it is settled here
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_item(f, k, c, n, v);
        sent++;
    endtask

    // Hold off the sender until every owed result has come back
    task automatic hold_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return VAL_LEAST;
            1: return VAL_MOST;
            2: return $signed($urandom_range(0, 511)) - 256;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        issue(tli_pkg::FUNC_CLEAR, KEY_TOP, 4'hF, 5'h1F, -1);
        // empty table, write with nothing open, count above the limit
        issue(tli_pkg::FUNC_QUERY, 24'd5, 4'd0, 5'd0, 0);
        issue(tli_pkg::FUNC_WRITE, 24'd0, 4'd0, 5'd0, 32'sd7);
        issue(tli_pkg::FUNC_OPEN, 24'h000010, 4'd0, 5'd31, 0);
        issue(tli_pkg::FUNC_OPEN, 24'h000010, 4'd0, 5'd2, 0);
        issue(tli_pkg::FUNC_WRITE, 24'd0, 4'd2, 5'd0, 32'sd1);
        issue(tli_pkg::FUNC_WRITE, 24'd0, 4'd0, 5'd0, VAL_LEAST);
        issue(tli_pkg::FUNC_WRITE, 24'd0, 4'd1, 5'd0, VAL_MOST);
        // duplicate and descending keys
        issue(tli_pkg::FUNC_OPEN, 24'h000010, 4'd0, 5'd2, 0);
        issue(tli_pkg::FUNC_OPEN, 24'h00000F, 4'd0, 5'd2, 0);
        issue(tli_pkg::FUNC_OPEN, KEY_TOP, 4'd0, 5'd16, 0);
        issue(tli_pkg::FUNC_WRITE, 24'd0, 4'd15, 5'd0, VAL_MOST);
        issue(tli_pkg::FUNC_WRITE, 24'd0, 4'd0, 5'd0, VAL_MOST);
        issue(tli_pkg::FUNC_WRITE, 24'd0, 4'd1, 5'd0, VAL_LEAST);
        // below, on the first key, mid span, at the last key, missing component
        issue(tli_pkg::FUNC_QUERY, 24'h00000F, 4'd0, 5'd0, 0);
        issue(tli_pkg::FUNC_QUERY, 24'h000010, 4'd0, 5'd0, 0);
        issue(tli_pkg::FUNC_QUERY, 24'h800000, 4'd1, 5'd0, 0);
        issue(tli_pkg::FUNC_QUERY, 24'h7FFFFF, 4'd0, 5'd0, 0);
        issue(tli_pkg::FUNC_QUERY, KEY_TOP, 4'd0, 5'd0, 0);
        issue(tli_pkg::FUNC_QUERY, 24'h7FFFFF, 4'd5, 5'd0, 0);
        issue(tli_pkg::FUNC_QUERY, 24'd0, 4'd15, 5'd0, 0);
        issue(tli_pkg::FUNC_OPEN, KEY_TOP, 4'd0, 5'd0, 0);
        hold_until_drained();
        issue(tli_pkg::FUNC_CLEAR, 24'd0, 4'd0, 5'd0, 0);
        issue(tli_pkg::FUNC_QUERY, KEY_TOP, 4'd15, 5'd16, VAL_LEAST);
    endtask

    // Load the components of the entry just opened, with a few rejected writes
    task automatic load_entry(input int cnt);
        for (int j = 0; j < cnt; j++)
        begin
            if ($urandom_range(11) != 0)
                issue(tli_pkg::FUNC_WRITE, KEY_W'($urandom), COMP_W'(j),
                      CNT_W'($urandom), pick_value());
            if (cnt < COMPS && $urandom_range(7) == 0)
                issue(tli_pkg::FUNC_WRITE, KEY_W'($urandom),
                      COMP_W'($urandom_range(cnt, COMPS - 1)), CNT_W'($urandom),
                      pick_value());
        end
    endtask

    // Build a table in ascending key order, then query it
    task automatic run_episode();
        int  n_opens, n_queries, cnt, step, last, before_total;
        int  next_key;
        bit  fill_up;
        logic [KEY_W-1:0]  qk;
        logic [COMP_W-1:0] qc;
        if ($urandom_range(3) != 0)
            issue(tli_pkg::FUNC_CLEAR, KEY_W'($urandom), COMP_W'($urandom),
                  CNT_W'($urandom), $urandom);
        fill_up = ($urandom_range(11) == 0);
        n_opens = fill_up ? ENTRIES + 4 : $urandom_range(1, 8);
        for (int i = 0; i < n_opens; i++)
        begin
            case (fill_up ? $urandom_range(1) : $urandom_range(3))
                0: step = 1;
                1: step = $urandom_range(1, 255);
                2: step = $urandom_range(1, 65535);
                default: step = $urandom_range(1, 1 << 20);
            endcase
            if (sb.entries == 0)
                next_key = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 1 << 16);
            else if ($urandom_range(9) == 0)
                next_key = sb.keys[sb.entries-1] - $urandom_range(0, 1);
            else
                next_key = sb.keys[sb.entries-1] + step;
            if (next_key > KEY_TOP || next_key < 0)
                next_key = KEY_TOP;
            if (fill_up)
                cnt = $urandom_range(0, 2);
            else
                case ($urandom_range(9))
                    0: cnt = 0;
                    1: cnt = COMPS;
                    2: cnt = $urandom_range(COMPS + 1, 31);
                    default: cnt = $urandom_range(1, 4);
                endcase
            before_total = sb.entries;
            issue(tli_pkg::FUNC_OPEN, KEY_W'(next_key), COMP_W'($urandom), CNT_W'(cnt),
                  $urandom);
            if (sb.entries > before_total)
                load_entry(cnt);
        end

        n_queries = fill_up ? 12 : $urandom_range(2, 8);
        for (int i = 0; i < n_queries; i++)
        begin
            last = sb.entries - 1;
            if (sb.entries == 0)
                qk = KEY_W'($urandom);
            else
                case ($urandom_range(5))
                    0: qk = KEY_W'($urandom);
                    1: qk = KEY_W'($urandom_range(sb.keys[0], sb.keys[last]));
                    2: qk = sb.keys[$urandom_range(0, last)];
                    3: qk = (sb.keys[0] == 0) ? '0
                                              : KEY_W'($urandom_range(0, sb.keys[0] - 1));
                    4: qk = KEY_W'($urandom_range(sb.keys[last], KEY_TOP));
                    default: qk = KEY_W'(sb.keys[$urandom_range(0, last)]
                                         + $urandom_range(0, 3));
                endcase
            qc = $urandom_range(1) ? COMP_W'($urandom_range(0, 3))
                                   : COMP_W'($urandom_range(0, COMPS - 1));
            // skip lookups that would land on a component never loaded
            if (!sb.reads_unwritten(qk, qc))
                issue(tli_pkg::FUNC_QUERY, qk, qc, CNT_W'($urandom), $urandom);
        end
        if ($urandom_range(7) == 0)
            hold_until_drained();
    endtask

    initial
    begin
        int pcts [4];
        sb = new();
        pcts = '{0, 73, 0, 22};
        idle_pct     = 0;
        sent         = 0;
        quiet_cycles = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = tli_pkg::FUNC_CLEAR;
        key        = '0;
        component  = '0;
        comp_count = '0;
        value      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // random phases, two of them all back-to-back, the others with occasional bursts of back-to-back commands
        for (int p = 0; p < 4; p++)
        begin
            while (sent < 25 + ITEMS_PER_PHASE * (p + 1))
            begin
                idle_pct = ($urandom_range(4) == 0) ? 0 : pcts[p];
                run_episode();
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/tli_pkg.sv
design/tli_ctrl.sv
design/tli_dpath.sv
design/table_linear_interpolator.sv
design/tli_checker.sv
sim/tb.sv
